// ===== rtl/framed_command_responder_macros.svh =====
// Assertion macros for the framed command responder RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FRAMED_COMMAND_RESPONDER_MACROS_SVH
`define FRAMED_COMMAND_RESPONDER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FCR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcr assertion failed");
// next-cycle implication
`define FCR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcr assertion failed");
`else
`define FCR_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fcr_pkg.sv =====
// Shared types and constants for the framed command responder.
// No dependencies; used by fcr_parser, fcr_serializer and the top level.
package fcr_pkg;

   localparam int BUFFER_SIZE = 10;
   localparam logic [7:0] MAX_FRAME_END = 8'(BUFFER_SIZE - 1);

   localparam int REPLY_LEN = 10;
   localparam logic [7:0] REPLY_LEN_BYTE = 8'(REPLY_LEN);
   localparam int COUNT_W = $clog2(REPLY_LEN + 1);

   localparam logic [7:0] CMD_REQUEST = 8'h20;
   localparam logic [7:0] CMD_REPLY = 8'h21;

   localparam logic [7:0] HEADER_RESET = 8'h55;
   localparam logic [7:0] FRAME_END_RESET = 8'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_HEADER = 1'b0,
      REG_NONE = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_HUNT,
      ST_FRAME
   } parse_state_type;

   // snapshot handed from the parser to the reply serializer
   typedef struct packed {
      logic fire;
      logic [7:0] header;
      logic [15:0] sensor_one;
      logic [15:0] sensor_two;
      logic [7:0] led_one;
      logic [7:0] led_two;
   } reply_launch_type;

endpackage

// ===== rtl/fcr_parser.sv =====
// Frame parser: header hunt, length clamp, running sum and command capture.
// Depends on fcr_pkg and framed_command_responder_macros.svh.
`include "framed_command_responder_macros.svh"

module fcr_parser (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] rx_byte,
   input  logic [15:0] sensor_one,
   input  logic [15:0] sensor_two,
   input  logic [7:0] led_one_state,
   input  logic [7:0] led_two_state,
   input  logic [7:0] header_value,
   output fcr_pkg::reply_launch_type launch,
   output logic end_possible
);

   fcr_pkg::parse_state_type state_ff, state_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] frame_end_ff, frame_end_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff, cmd_in;

   logic [7:0] pos_next;
   logic [7:0] len_clamped;
   logic [8:0] pos_plus;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcr_pkg::ST_HUNT;
         pos_ff <= '0;
         frame_end_ff <= fcr_pkg::FRAME_END_RESET;
         sum_ff <= '0;
         cmd_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         frame_end_ff <= frame_end_in;
         sum_ff <= sum_in;
         cmd_ff <= cmd_in;
      end
   end

   assign pos_next = pos_ff + 8'd1;
   assign pos_plus = {1'b0, pos_ff} + 9'd1;

   always_comb begin
      if (rx_byte == 8'd0) begin
         len_clamped = 8'd1;
      end else if (rx_byte > fcr_pkg::MAX_FRAME_END) begin
         len_clamped = fcr_pkg::MAX_FRAME_END;
      end else begin
         len_clamped = rx_byte;
      end
   end

   // a reply can only come out of the transaction that closes a frame
   assign end_possible = (state_ff == fcr_pkg::ST_FRAME) &&
                         ((pos_ff == 8'd0) || (pos_plus >= {1'b0, frame_end_ff}));

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      frame_end_in = frame_end_ff;
      sum_in = sum_ff;
      cmd_in = cmd_ff;
      launch.fire = 1'b0;
      launch.header = header_value;
      launch.sensor_one = sensor_one;
      launch.sensor_two = sensor_two;
      launch.led_one = led_one_state;
      launch.led_two = led_two_state;
      if (accept) begin
         case (state_ff)
            fcr_pkg::ST_HUNT: begin
               if (rx_byte == header_value) begin
                  state_in = fcr_pkg::ST_FRAME;
                  pos_in = '0;
                  sum_in = rx_byte;
               end
            end
            fcr_pkg::ST_FRAME: begin
               pos_in = pos_next;
               if (pos_next == 8'd1) begin
                  frame_end_in = len_clamped;
               end
               if (pos_next == 8'd2) begin
                  cmd_in = rx_byte;
               end
               if (pos_next < frame_end_in) begin
                  sum_in = sum_ff + rx_byte;
               end else begin
                  // rx_byte is the checksum here
                  state_in = fcr_pkg::ST_HUNT;
                  launch.fire = (sum_ff == rx_byte) && (cmd_in == fcr_pkg::CMD_REQUEST);
               end
            end
            default: begin
               state_in = fcr_pkg::ST_HUNT;
            end
         endcase
      end
   end

   `FCR_ASSERT_IMP(a_fire_in_frame, clock, reset, launch.fire, state_ff == fcr_pkg::ST_FRAME && end_possible)
   `FCR_ASSERT_IMP(a_pos_below_end, clock, reset, state_ff == fcr_pkg::ST_FRAME, pos_ff < frame_end_ff && frame_end_ff != 8'd0)

endmodule

// ===== rtl/fcr_serializer.sv =====
// Reply serializer: builds the ten-byte reply and shifts it out byte by byte.
// Depends on fcr_pkg and framed_command_responder_macros.svh.
`include "framed_command_responder_macros.svh"

module fcr_serializer (
   input  logic clock,
   input  logic reset,
   input  fcr_pkg::reply_launch_type launch,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last_of_frame,
   output logic idle
);

   logic [7:0] buf_ff [fcr_pkg::REPLY_LEN];
   logic [7:0] buf_in [fcr_pkg::REPLY_LEN];
   logic [fcr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0] checksum;
   logic take;

   assign take = rsp_valid && rsp_ready;

   assign checksum = 8'(launch.header + fcr_pkg::REPLY_LEN_BYTE +
                        launch.sensor_one[7:0] + launch.sensor_one[15:8] +
                        launch.sensor_two[7:0] + launch.sensor_two[15:8] +
                        launch.led_one + launch.led_two + fcr_pkg::CMD_REPLY);

   always_comb begin
      buf_in = buf_ff;
      count_in = count_ff;
      if (launch.fire) begin
         buf_in[0] = launch.header;
         buf_in[1] = fcr_pkg::REPLY_LEN_BYTE;
         buf_in[2] = launch.sensor_one[7:0];
         buf_in[3] = launch.sensor_one[15:8];
         buf_in[4] = launch.sensor_two[7:0];
         buf_in[5] = launch.sensor_two[15:8];
         buf_in[6] = launch.led_one;
         buf_in[7] = launch.led_two;
         buf_in[8] = fcr_pkg::CMD_REPLY;
         buf_in[9] = checksum;
         count_in = fcr_pkg::COUNT_W'(fcr_pkg::REPLY_LEN);
      end else if (take) begin
         for (int i = 0; i < fcr_pkg::REPLY_LEN - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_tx_byte = buf_ff[0];
   assign rsp_last_of_frame = (count_ff == fcr_pkg::COUNT_W'(1));
   assign idle = (count_ff == '0);

   `FCR_ASSERT_IMP(a_load_when_empty, clock, reset, launch.fire, count_ff == '0)
   `FCR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= fcr_pkg::COUNT_W'(fcr_pkg::REPLY_LEN))
   `FCR_ASSERT_NXT(a_gap_after_last, clock, reset, take && rsp_last_of_frame, !rsp_valid)

endmodule

// ===== rtl/framed_command_responder.sv =====
// Top level of the framed command responder: CSR port, parser and reply serializer.
// Depends on fcr_pkg, fcr_parser and fcr_serializer.
//
// Usage:
//   req_* carries one received serial byte per transaction together with the
//   current sensor and LED values. rsp_* returns reply bytes, one per
//   transaction, with rsp_last_of_frame high on the tenth byte.
//   csr_* is an APB-style port; register 0 (byte address 0) is the header byte.
// Timing:
//   Each request transaction is parsed in the cycle it is accepted; a request
//   is taken every cycle while req_ready is high. When it closes a valid
//   command frame, the first reply byte is on rsp_* in the next cycle and the
//   ten bytes leave at up to one per cycle from a shift register.
//   req_ready drops only for a byte that could close a frame while an earlier
//   reply is still draining; all other bytes are accepted meanwhile.
// Reset:
//   Synchronous, active high. Header returns to 0x55, the parser hunts for a
//   header and any pending reply is discarded.
// Stall:
//   A low rsp_ready holds the current reply byte; parsing continues until a
//   byte that may finish a frame arrives.
module framed_command_responder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic [15:0] req_sensor_one,
   input  logic [15:0] req_sensor_two,
   input  logic [7:0] req_led_one_state,
   input  logic [7:0] req_led_two_state,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last_of_frame,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic [7:0] header_ff, header_in;
   fcr_pkg::csr_index_type csr_index;
   fcr_pkg::reply_launch_type launch;
   logic end_possible;
   logic ser_idle;
   logic accept;

   assign csr_pready = 1'b1;
   assign csr_index = fcr_pkg::csr_index_type'(csr_paddr[fcr_pkg::CSR_ADDR_W-1]);

   always_comb begin
      header_in = header_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_index == fcr_pkg::REG_HEADER)) begin
         header_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= fcr_pkg::HEADER_RESET;
      end else begin
         header_ff <= header_in;
      end
   end

   always_comb begin
      case (csr_index)
         fcr_pkg::REG_HEADER: csr_prdata = {{(fcr_pkg::CSR_DATA_W - 8){1'b0}}, header_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign req_ready = !end_possible || ser_idle;
   assign accept = req_valid && req_ready;

   fcr_parser u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .sensor_one(req_sensor_one),
      .sensor_two(req_sensor_two),
      .led_one_state(req_led_one_state),
      .led_two_state(req_led_two_state),
      .header_value(header_ff),
      .launch(launch),
      .end_possible(end_possible)
   );

   fcr_serializer u_serializer (
      .clock(clock),
      .reset(reset),
      .launch(launch),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last_of_frame(rsp_last_of_frame),
      .idle(ser_idle)
   );

endmodule
